>>> hdl/lcgps_pkg.sv
// ----------------------------------------------------------------------------
// lcgps_pkg
// Shared constants, operation codes and inter-module types for the LCG
// pick-and-shuffle core.
// ----------------------------------------------------------------------------
package lcgps_pkg;

  localparam int FUNC_W  = 3;
  localparam int STATE_W = 31;
  localparam int ITEM_W  = 32;
  localparam int LANES   = 4;

  localparam int DIGIT_W = 8;
  localparam int DIGITS  = 4;
  localparam int CNT_W   = $clog2(DIGITS);
  localparam int PROD_W  = STATE_W + DIGIT_W;

  localparam logic [DIGITS*DIGIT_W-1:0] LCG_MUL = 32'h41C6_4E6D;
  localparam logic [STATE_W-1:0]        LCG_ADD = 31'd12345;

  localparam int SEED_STEPS = 4;
  localparam int STEPS_W    = $clog2(SEED_STEPS + 1);

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEED  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PICK4 = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_PICK3 = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SHUF3 = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_SHUF4 = 3'd5;

  typedef struct packed {
    logic               start;
    logic [STATE_W-1:0] state;
  } lcgps_step_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [STATE_W-1:0] state;
  } lcgps_step_rsp_t;

endpackage

>>> hdl/lcgps_if.sv
// ----------------------------------------------------------------------------
// lcgps_in_if / lcgps_out_if
// Valid/ready channels for requests into and results out of the core.
// ----------------------------------------------------------------------------
interface lcgps_in_if;
  logic                                     valid;
  logic                                     ready;
  logic        [lcgps_pkg::FUNC_W-1:0]      func;
  logic        [lcgps_pkg::STATE_W-1:0]     seed_value;
  logic signed [lcgps_pkg::ITEM_W-1:0]      item_first;
  logic signed [lcgps_pkg::ITEM_W-1:0]      item_second;
  logic signed [lcgps_pkg::ITEM_W-1:0]      item_third;
  logic signed [lcgps_pkg::ITEM_W-1:0]      item_fourth;

  modport source (
    output valid, func, seed_value, item_first, item_second, item_third, item_fourth,
    input  ready
  );
  modport sink (
    input  valid, func, seed_value, item_first, item_second, item_third, item_fourth,
    output ready
  );
endinterface

interface lcgps_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [lcgps_pkg::ITEM_W-1:0]      out_first;
  logic signed [lcgps_pkg::ITEM_W-1:0]      out_second;
  logic signed [lcgps_pkg::ITEM_W-1:0]      out_third;
  logic signed [lcgps_pkg::ITEM_W-1:0]      out_fourth;
  logic        [lcgps_pkg::STATE_W-1:0]     new_state;

  modport source (
    output valid, out_first, out_second, out_third, out_fourth, new_state,
    input  ready
  );
  modport sink (
    input  valid, out_first, out_second, out_third, out_fourth, new_state,
    output ready
  );
endinterface

>>> hdl/lcg_random_pick_and_shuffle_core.sv
// ----------------------------------------------------------------------------
// lcg_random_pick_and_shuffle_core
// 31-bit LCG with load, seed-and-warmup, pick and shuffle operations.
//
//   channel  dir  handshake           payload
//   in_ch    in   valid/ready         func, seed_value, item_first..fourth
//   out_ch   out  valid/ready         out_first..out_fourth, new_state
//
// One request in flight at a time; every generator step runs through the
// shared digit-serial multiplier, four 8-bit digits per step. Load and
// unused codes run no generator step; single-step operations run one;
// seed with warmup runs four.
// Reset is synchronous, active low, and clears the generator state to zero.
// A stalled result sits in the output register while the next request is
// accepted; the core holds in finish until that register is free.
// ----------------------------------------------------------------------------
module lcg_random_pick_and_shuffle_core (
  input  logic          clk,
  input  logic          rst_n,
  lcgps_in_if.sink      in_ch,
  lcgps_out_if.source   out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } fsm_t;

  typedef logic [lcgps_pkg::LANES-1:0][lcgps_pkg::ITEM_W-1:0] lane_t;

  fsm_t                              fsm_r;
  logic                              start_r;
  logic [lcgps_pkg::STEPS_W-1:0]     steps_left_r;
  logic [lcgps_pkg::STATE_W-1:0]     rng_r;
  logic [lcgps_pkg::FUNC_W-1:0]      func_r;
  lane_t                             items_r;
  lane_t                             res_r;
  logic [lcgps_pkg::STATE_W-1:0]     new_state_r;
  logic                              out_valid_r;

  lcgps_pkg::lcgps_step_req_t        step_req;
  lcgps_pkg::lcgps_step_rsp_t        step_rsp;

  logic                              in_fire;
  logic                              out_free;
  logic [lcgps_pkg::ITEM_W-1:0]      three_lo30;
  logic [lcgps_pkg::STATE_W-2:0]     three_lo28;
  logic [1:0]                        n_pick3;
  logic [1:0]                        n_quart;
  lane_t                             sw1;
  lane_t                             sw2;
  lane_t                             sw3;
  lane_t                             res;

  function automatic lane_t swap_lanes(lane_t v, logic [1:0] i, logic [1:0] j);
    lane_t w;
    w    = v;
    w[i] = v[j];
    w[j] = v[i];
    return w;
  endfunction

  assign in_ch.ready = (fsm_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign step_req.start = start_r;
  assign step_req.state = rng_r;

  lcgps_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (step_req),
    .rsp   (step_rsp)
  );

  always_comb begin
    three_lo30 = {2'b00, rng_r[29:0]} + {1'b0, rng_r[29:0], 1'b0};
    three_lo28 = {2'b00, rng_r[27:0]} + {1'b0, rng_r[27:0], 1'b0};
    n_pick3    = three_lo30[31:30];
    n_quart    = three_lo28[29:28];
    sw1        = swap_lanes(items_r, {1'b0, rng_r[30]}, 2'd1);
    sw2        = swap_lanes(sw1, (func_r == lcgps_pkg::FUNC_SHUF4) ? n_quart : n_pick3, 2'd2);
    sw3        = swap_lanes(sw2, rng_r[29:28], 2'd3);
    res        = '0;
    unique case (func_r)
      lcgps_pkg::FUNC_PICK4: res[0] = {30'd0, rng_r[30:29]};
      lcgps_pkg::FUNC_PICK3: begin
        if (n_pick3 == 2'd0) begin
          res[0] = items_r[0];
        end else if (n_pick3 == 2'd1) begin
          res[0] = items_r[1];
        end else begin
          res[0] = items_r[2];
        end
      end
      lcgps_pkg::FUNC_SHUF3: begin
        res[0] = sw2[0];
        res[1] = sw2[1];
        res[2] = sw2[2];
      end
      lcgps_pkg::FUNC_SHUF4: res = sw3;
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r        <= S_IDLE;
      start_r      <= 1'b0;
      steps_left_r <= '0;
      rng_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (fsm_r)
        S_IDLE: begin
          if (in_fire) begin
            func_r     <= in_ch.func;
            items_r[0] <= $unsigned(in_ch.item_first);
            items_r[1] <= $unsigned(in_ch.item_second);
            items_r[2] <= $unsigned(in_ch.item_third);
            items_r[3] <= $unsigned(in_ch.item_fourth);
            unique case (in_ch.func) inside
              lcgps_pkg::FUNC_LOAD: begin
                rng_r <= in_ch.seed_value;
                fsm_r <= S_FINISH;
              end
              lcgps_pkg::FUNC_SEED: begin
                rng_r        <= in_ch.seed_value;
                steps_left_r <= lcgps_pkg::STEPS_W'(lcgps_pkg::SEED_STEPS);
                start_r      <= 1'b1;
                fsm_r        <= S_RUN;
              end
              lcgps_pkg::FUNC_PICK4, lcgps_pkg::FUNC_PICK3,
              lcgps_pkg::FUNC_SHUF3, lcgps_pkg::FUNC_SHUF4: begin
                steps_left_r <= lcgps_pkg::STEPS_W'(1);
                start_r      <= 1'b1;
                fsm_r        <= S_RUN;
              end
              default: fsm_r <= S_FINISH;
            endcase
          end
        end
        S_RUN: begin
          if (step_rsp.done) begin
            rng_r        <= step_rsp.state;
            steps_left_r <= steps_left_r - 1'b1;
            if (steps_left_r == lcgps_pkg::STEPS_W'(1)) begin
              fsm_r <= S_FINISH;
            end else begin
              start_r <= 1'b1;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            res_r       <= res;
            new_state_r <= rng_r;
            out_valid_r <= 1'b1;
            fsm_r       <= S_IDLE;
          end
        end
        default: fsm_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_first  = $signed(res_r[0]);
  assign out_ch.out_second = $signed(res_r[1]);
  assign out_ch.out_third  = $signed(res_r[2]);
  assign out_ch.out_fourth = $signed(res_r[3]);
  assign out_ch.new_state  = new_state_r;

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    step_rsp.done |-> (fsm_r == S_RUN))
    else $error("step result outside run state");

  a_accept_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!step_rsp.busy && !start_r))
    else $error("request accepted while multiplier busy");

  a_load_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.func == lcgps_pkg::FUNC_LOAD) |=> (rng_r == $past(in_ch.seed_value)))
    else $error("load did not set generator state");

  a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_left_r <= lcgps_pkg::STEPS_W'(lcgps_pkg::SEED_STEPS))
    else $error("step count out of range");

endmodule

>>> hdl/lcgps_step.sv
// ----------------------------------------------------------------------------
// lcgps_step
// One generator step, state * 1103515245 + 12345 mod 2^31, computed one
// 8-bit multiplier digit per cycle over a shifting multiplicand.
// ----------------------------------------------------------------------------
module lcgps_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcgps_pkg::lcgps_step_req_t  req,
  output lcgps_pkg::lcgps_step_rsp_t  rsp
);

  logic                                           busy_r;
  logic                                           done_r;
  logic [lcgps_pkg::CNT_W-1:0]                    cnt_r;
  logic [lcgps_pkg::STATE_W-1:0]                  mcand_r;
  logic [lcgps_pkg::STATE_W-1:0]                  acc_r;
  logic [lcgps_pkg::DIGITS*lcgps_pkg::DIGIT_W-1:0] digit_r;
  logic [lcgps_pkg::PROD_W-1:0]                   prod;

  assign prod = lcgps_pkg::PROD_W'(mcand_r) *
                lcgps_pkg::PROD_W'(digit_r[lcgps_pkg::DIGIT_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        cnt_r   <= '0;
        mcand_r <= req.state;
        acc_r   <= lcgps_pkg::LCG_ADD;
        digit_r <= lcgps_pkg::LCG_MUL;
      end else if (busy_r) begin
        acc_r   <= acc_r + prod[lcgps_pkg::STATE_W-1:0];
        mcand_r <= mcand_r << lcgps_pkg::DIGIT_W;
        digit_r <= digit_r >> lcgps_pkg::DIGIT_W;
        cnt_r   <= cnt_r + 1'b1;
        if (cnt_r == lcgps_pkg::CNT_W'(lcgps_pkg::DIGITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.state = acc_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("step started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start && cnt_r == lcgps_pkg::CNT_W'(lcgps_pkg::DIGITS - 1)) |=> done_r)
    else $error("step did not finish after last digit");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("done raised while busy");

endmodule
